// ----- sv/piezo_hit_detector_defines.svh -----
// Assertion macros shared by the checker.
`ifndef PIEZO_HIT_DETECTOR_DEFINES_SVH
`define PIEZO_HIT_DETECTOR_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define PHD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("piezo_hit_detector: assertion failed");

// next-cycle implication, off while reset is asserted
`define PHD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("piezo_hit_detector: assertion failed");

`endif

// ----- sv/phd_pkg.sv -----
`timescale 1ns / 1ps
package phd_pkg;

	localparam int LEVEL_W        = 10;
	localparam int SAMPLE_BITS    = LEVEL_W;
	localparam int TIME_W         = 32;
	localparam int PHASE_W        = 3;
	localparam int VEL_W          = 7;
	localparam int PEAK_WINDOW_MS = 7;
	localparam int CFG_IDX_W      = 2;

	localparam logic [PHASE_W-1:0] PH_UNDER  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SIGNAL = 3'd1;
	localparam logic [PHASE_W-1:0] PH_RISING = 3'd2;
	localparam logic [PHASE_W-1:0] PH_PEAK   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_WINDOW = 3'd4;
	localparam logic [PHASE_W-1:0] PH_SEND   = 3'd5;
	localparam logic [PHASE_W-1:0] PH_FALL   = 3'd6;
	localparam logic [PHASE_W-1:0] PH_UNUSED = 3'd7;

	localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic latch_in;
		logic div_start;
		logic commit;
	} phd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_vel;
		logic div_busy;
	} phd_sts_t;

endpackage

// ----- sv/phd_if.sv -----
`timescale 1ns / 1ps
interface phd_in_if;
	logic                             valid;
	logic                             ready;
	logic [phd_pkg::SAMPLE_BITS-1:0]  sample;
	logic [phd_pkg::TIME_W-1:0]       now_ms;

	modport source (output valid, output sample, output now_ms, input ready);
	modport sink (input valid, input sample, input now_ms, output ready);
endinterface

interface phd_out_if;
	logic                          valid;
	logic                          ready;
	logic [phd_pkg::PHASE_W-1:0]   hit_phase;
	logic                          note_on;
	logic [phd_pkg::VEL_W-1:0]     velocity;
	logic [phd_pkg::LEVEL_W-1:0]   peak_level;

	modport source (output valid, output hit_phase, output note_on, output velocity,
		output peak_level, input ready);
	modport sink (input valid, input hit_phase, input note_on, input velocity,
		input peak_level, output ready);
endinterface

// ----- sv/phd_ctrl.sv -----
`timescale 1ns / 1ps
module phd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  phd_pkg::phd_sts_t sts,
	output phd_pkg::phd_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] st_q;
	logic [1:0] st_d;
	logic       out_valid_q;
	logic       out_free;

	// the state registers double as the output register
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (st_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		st_d          = st_q;
		cmd.latch_in  = 1'b0;
		cmd.div_start = 1'b0;
		cmd.commit    = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					st_d         = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.need_vel) begin
					cmd.div_start = 1'b1;
					st_d          = ST_DIV;
				end else if (out_free) begin
					cmd.commit = 1'b1;
					st_d       = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (!sts.div_busy) begin
					st_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					st_d       = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/phd_dp.sv -----
`timescale 1ns / 1ps
module phd_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  phd_pkg::phd_cmd_t                 cmd,
	output phd_pkg::phd_sts_t                 sts,
	input  logic [phd_pkg::SAMPLE_BITS-1:0]   sample,
	input  logic [phd_pkg::TIME_W-1:0]        now_ms,
	input  logic                              cfg_we,
	input  logic [phd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [phd_pkg::LEVEL_W-1:0]       cfg_data,
	output logic [phd_pkg::PHASE_W-1:0]       hit_phase,
	output logic                              note_on,
	output logic [phd_pkg::VEL_W-1:0]         velocity,
	output logic [phd_pkg::LEVEL_W-1:0]       peak_level
);

	localparam int LW        = phd_pkg::LEVEL_W;
	localparam int PROD_W    = LW + phd_pkg::VEL_W;
	localparam int DIV_STEPS = PROD_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int DIFF_W    = PROD_W + 3;
	localparam int VEL_MAX   = 127;

	// 127 * x as shift and subtract
	function automatic logic [PROD_W-1:0] mul127(input logic [LW-1:0] x);
		mul127 = PROD_W'({x, 7'b0}) - PROD_W'(x);
	endfunction

	// x / 3 via reciprocal 683 / 2048, exact for x below 2048
	function automatic logic [LW-1:0] div3(input logic [LW-1:0] x);
		logic [LW+10:0] p;
		p    = (LW + 11)'(x) * (LW + 11)'(683);
		div3 = p[LW+10:11];
	endfunction

	// config
	logic [LW-1:0] sens_q;
	logic [LW-1:0] thr_q;
	logic [LW-1:0] deb_q;

	// hit state
	logic [phd_pkg::PHASE_W-1:0] phase_q;
	logic [LW-1:0]               prev_q;
	logic [LW-1:0]               peak_q;
	logic [LW-1:0]               fall_q;
	logic [phd_pkg::TIME_W-1:0]  hit_q;
	logic [phd_pkg::VEL_W-1:0]   vel_q;

	// latched beat
	logic [LW-1:0]               s_q;
	logic [phd_pkg::TIME_W-1:0]  now_q;

	// divider, lane 0 = 127*peak, lane 1 = 127*sens
	logic [LW-1:0]     rem_q [2];
	logic [PROD_W-1:0] quo_q [2];
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	logic [phd_pkg::PHASE_W-1:0] ph1;
	logic [phd_pkg::PHASE_W-1:0] ph2;
	logic [LW-1:0]               fall_d;
	logic [LW-1:0]               peak_d;
	logic [phd_pkg::TIME_W-1:0]  hit_d;
	logic [phd_pkg::TIME_W-1:0]  elapsed;
	logic                        new_peak;

	logic signed [LW:0]          dsig;
	logic [LW-1:0]               dmag;
	logic                        d_neg;
	logic                        d_zero;
	logic [LW:0]                 rem_raw [2];
	logic                        ge [2];
	logic signed [DIFF_W-1:0]    diff;
	logic signed [DIFF_W-1:0]    vsum;
	logic [phd_pkg::VEL_W-1:0]   vel_div;

	assign elapsed = now_q - hit_q;

	always_comb begin
		ph1    = phase_q;
		fall_d = fall_q;
		case (phase_q)
			phd_pkg::PH_UNDER: begin
				if (s_q > fall_q && s_q > prev_q) begin
					ph1 = phd_pkg::PH_SIGNAL;
				end
				if (fall_q > thr_q) begin
					fall_d = fall_q - 1'b1;
				end
			end
			phd_pkg::PH_SIGNAL: begin
				if (s_q > peak_q) begin
					ph1 = phd_pkg::PH_RISING;
				end
			end
			phd_pkg::PH_RISING: begin
				if (s_q < prev_q) begin
					ph1 = phd_pkg::PH_PEAK;
				end
			end
			phd_pkg::PH_WINDOW: begin
				ph1 = (elapsed > phd_pkg::TIME_W'(phd_pkg::PEAK_WINDOW_MS)) ?
					phd_pkg::PH_SEND : phd_pkg::PH_PEAK;
			end
			phd_pkg::PH_SEND: begin
				ph1 = phd_pkg::PH_FALL;
			end
			phd_pkg::PH_FALL: begin
				if (s_q < fall_q && elapsed > phd_pkg::TIME_W'(deb_q)) begin
					fall_d = div3(peak_q);
					ph1    = phd_pkg::PH_UNDER;
				end
			end
			default: begin
				ph1 = phase_q;
			end
		endcase
	end

	always_comb begin
		ph2      = ph1;
		peak_d   = peak_q;
		hit_d    = hit_q;
		new_peak = 1'b0;
		case (ph1)
			phd_pkg::PH_UNDER: begin
				peak_d = '0;
			end
			phd_pkg::PH_SIGNAL: begin
				hit_d = now_q;
			end
			phd_pkg::PH_PEAK: begin
				if (peak_q < s_q) begin
					peak_d   = s_q;
					new_peak = 1'b1;
				end
				ph2 = phd_pkg::PH_WINDOW;
			end
			default: begin
				ph2 = ph1;
			end
		endcase
	end

	assign sts.need_vel = new_peak;
	assign sts.div_busy = busy_q;

	// divisor magnitude, shared by both lanes
	assign dsig   = $signed({1'b0, sens_q}) - $signed({1'b0, thr_q});
	assign d_neg  = dsig[LW];
	assign d_zero = (dsig == '0);
	assign dmag   = d_neg ? LW'(-dsig) : LW'(dsig);

	for (genvar l = 0; l < 2; l++) begin : g_lane
		assign rem_raw[l] = {rem_q[l], quo_q[l][PROD_W-1]};
		assign ge[l]      = (rem_raw[l] >= {1'b0, dmag});
	end

	// v = 127 + sign(d) * (q0 - q1), each quotient truncated toward zero
	always_comb begin
		diff = $signed({3'b0, quo_q[0]}) - $signed({3'b0, quo_q[1]});
		vsum = d_neg ? (DIFF_W'(VEL_MAX) - diff) : (DIFF_W'(VEL_MAX) + diff);
		if (d_zero || vsum > DIFF_W'(VEL_MAX)) begin
			vel_div = phd_pkg::VEL_W'(VEL_MAX);
		end else if (vsum < DIFF_W'(1)) begin
			vel_div = phd_pkg::VEL_W'(1);
		end else begin
			vel_div = vsum[phd_pkg::VEL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			s_q   <= sample;
			now_q <= now_ms;
		end
		if (cmd.div_start) begin
			rem_q[0] <= '0;
			rem_q[1] <= '0;
			quo_q[0] <= mul127(s_q);
			quo_q[1] <= mul127(sens_q);
		end else if (busy_q) begin
			for (int l = 0; l < 2; l++) begin
				rem_q[l] <= ge[l] ? LW'(rem_raw[l] - {1'b0, dmag}) : LW'(rem_raw[l]);
				quo_q[l] <= {quo_q[l][PROD_W-2:0], ge[l]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.div_start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q <= {LW{1'b1}};
			thr_q  <= '0;
			deb_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				phd_pkg::CFG_SENSITIVITY: sens_q <= cfg_data;
				phd_pkg::CFG_THRESHOLD:   thr_q  <= cfg_data;
				phd_pkg::CFG_DEBOUNCE:    deb_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= phd_pkg::PH_UNDER;
			prev_q  <= '0;
			peak_q  <= '0;
			fall_q  <= '0;
			hit_q   <= '0;
			vel_q   <= phd_pkg::VEL_W'(1);
		end else if (cmd.commit) begin
			phase_q <= ph2;
			prev_q  <= s_q;
			peak_q  <= peak_d;
			fall_q  <= fall_d;
			hit_q   <= hit_d;
			if (new_peak) begin
				vel_q <= vel_div;
			end
		end
	end

	assign hit_phase  = phase_q;
	assign note_on    = (phase_q == phd_pkg::PH_SEND);
	assign velocity   = vel_q;
	assign peak_level = peak_q;

endmodule

// ----- sv/piezo_hit_detector.sv -----
`timescale 1ns / 1ps
// channel   dir  fields
// in_ch     in   sample[9:0], now_ms[31:0]
// out_ch    out  hit_phase[2:0], note_on, velocity[6:0], peak_level[9:0]
// cfg       in   cfg_we, cfg_index[1:0], cfg_data[9:0]
//
// An item with no new peak is committed from the evaluation state; when the
// velocity is recomputed, both quotients come from a two-lane restoring divider,
// one quotient bit per cycle over 17 bits.
// Reset loads the hit state and the registers directly; no clearing pass.
// A new beat is taken while the previous result waits; the update of the hit
// state is held until out_ch has taken that result.
module piezo_hit_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	phd_in_if.sink                            in_ch,
	phd_out_if.source                         out_ch,
	input  logic                              cfg_we,
	input  logic [phd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [phd_pkg::LEVEL_W-1:0]       cfg_data
);

	phd_pkg::phd_cmd_t cmd;
	phd_pkg::phd_sts_t sts;

	phd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	phd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.sample     (in_ch.sample),
		.now_ms     (in_ch.now_ms),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.hit_phase  (out_ch.hit_phase),
		.note_on    (out_ch.note_on),
		.velocity   (out_ch.velocity),
		.peak_level (out_ch.peak_level)
	);

endmodule

// ----- sv/phd_checker.sv -----
`timescale 1ns / 1ps
`include "piezo_hit_detector_defines.svh"
module phd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [phd_pkg::PHASE_W-1:0]      hit_phase,
	input logic                             note_on,
	input logic [phd_pkg::VEL_W-1:0]        velocity,
	input logic [phd_pkg::LEVEL_W-1:0]      peak_level
);

	`PHD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(hit_phase) && $stable(note_on) && $stable(velocity) && $stable(peak_level))

	`PHD_ASSERT_IMP(a_note_send, clk, arst_n, out_valid, note_on == (hit_phase == phd_pkg::PH_SEND))

	`PHD_ASSERT_IMP(a_vel_nonzero, clk, arst_n, out_valid, velocity != '0)

	// peak is consumed in the same step, and under threshold clears it
	`PHD_ASSERT_IMP(a_phase_legal, clk, arst_n, out_valid, hit_phase != phd_pkg::PH_PEAK && hit_phase != phd_pkg::PH_UNUSED && (hit_phase != phd_pkg::PH_UNDER || peak_level == '0))

endmodule

bind piezo_hit_detector phd_checker u_phd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.hit_phase  (out_ch.hit_phase),
	.note_on    (out_ch.note_on),
	.velocity   (out_ch.velocity),
	.peak_level (out_ch.peak_level)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

	localparam int STALL_LIMIT = 4000;
	localparam int SWEEP_SEGMENTS = 6;
	localparam int SEGMENT_BEATS = 85;
	localparam int FALL_BEATS = 150;

	typedef struct packed {
		logic [phd_pkg::PHASE_W-1:0] hit_phase;
		logic                        note_on;
		logic [phd_pkg::VEL_W-1:0]   velocity;
		logic [phd_pkg::LEVEL_W-1:0] peak_level;
	} hit_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [phd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [phd_pkg::LEVEL_W-1:0]   cfg_data;

	phd_in_if  in_bus ();
	phd_out_if out_bus ();

	piezo_hit_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_bus),
		.out_ch    (out_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register shadow
	logic [phd_pkg::LEVEL_W-1:0] cfg_sens;
	logic [phd_pkg::LEVEL_W-1:0] cfg_thr;
	logic [phd_pkg::LEVEL_W-1:0] cfg_debounce;

	// hit state shadow
	logic [phd_pkg::PHASE_W-1:0] ph;
	logic [phd_pkg::LEVEL_W-1:0] last_level;
	logic [phd_pkg::LEVEL_W-1:0] peak_lvl;
	logic [phd_pkg::LEVEL_W-1:0] rearm_lvl;
	logic [phd_pkg::TIME_W-1:0]  onset_ms;
	logic [phd_pkg::VEL_W-1:0]   vel_now;

	hit_result_t hit_q[$];

	int src_gap_pct;
	int snk_stall_pct;
	int mismatches;
	int beats_sent;
	int results_seen;
	int settings_loaded;
	int vel_updates;
	int notes_due;
	int stall_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [phd_pkg::VEL_W-1:0] hit_velocity(
		input logic [phd_pkg::LEVEL_W-1:0] level);
		int lvl;
		int sens;
		int thr;
		int span;
		int v;
		lvl = int'(level);
		sens = int'(cfg_sens);
		thr = int'(cfg_thr);
		span = sens - thr;
		if (span == 0)
			return 7'd127;
		// signed division, truncating toward zero
		v = (127 * lvl) / span + 127 - (127 * sens) / span;
		if (v > 127)
			v = 127;
		if (v < 1)
			v = 1;
		return v[phd_pkg::VEL_W-1:0];
	endfunction

	task automatic clear_hit_state();
		cfg_sens = 10'd1023;
		cfg_thr = '0;
		cfg_debounce = '0;
		ph = phd_pkg::PH_UNDER;
		last_level = '0;
		peak_lvl = '0;
		rearm_lvl = '0;
		onset_ms = '0;
		vel_now = 7'd1;
	endtask

	task automatic predict_hit(input logic [phd_pkg::LEVEL_W-1:0] s,
		input logic [phd_pkg::TIME_W-1:0] now, output hit_result_t r);
		logic [phd_pkg::TIME_W-1:0] elapsed;
		elapsed = now - onset_ms;
		case (ph)
			phd_pkg::PH_UNDER: begin
				if (s > rearm_lvl && s > last_level)
					ph = phd_pkg::PH_SIGNAL;
				if (rearm_lvl > cfg_thr)
					rearm_lvl = rearm_lvl - 1'b1;
			end
			phd_pkg::PH_SIGNAL: begin
				if (s > peak_lvl)
					ph = phd_pkg::PH_RISING;
			end
			phd_pkg::PH_RISING: begin
				if (s < last_level)
					ph = phd_pkg::PH_PEAK;
			end
			phd_pkg::PH_WINDOW: begin
				ph = (elapsed > phd_pkg::TIME_W'(phd_pkg::PEAK_WINDOW_MS)) ?
					phd_pkg::PH_SEND : phd_pkg::PH_PEAK;
			end
			phd_pkg::PH_SEND: begin
				ph = phd_pkg::PH_FALL;
			end
			phd_pkg::PH_FALL: begin
				if (s < rearm_lvl && elapsed > phd_pkg::TIME_W'(cfg_debounce)) begin
					rearm_lvl = phd_pkg::LEVEL_W'(peak_lvl / 3);
					ph = phd_pkg::PH_UNDER;
				end
			end
			default: ;
		endcase
		case (ph)
			phd_pkg::PH_UNDER: begin
				peak_lvl = '0;
			end
			phd_pkg::PH_SIGNAL: begin
				onset_ms = now;
			end
			phd_pkg::PH_PEAK: begin
				if (peak_lvl < s) begin
					peak_lvl = s;
					vel_now = hit_velocity(s);
					vel_updates++;
				end
				// peak is never visible, it always moves on to the window
				ph = phd_pkg::PH_WINDOW;
			end
			default: ;
		endcase
		last_level = s;
		r.hit_phase = ph;
		r.note_on = (ph == phd_pkg::PH_SEND);
		r.velocity = vel_now;
		r.peak_level = peak_lvl;
		if (r.note_on)
			notes_due++;
	endtask

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("tb_top: mismatch: %s", what);
	endtask

	task automatic set_flow(input int src_pct, input int snk_pct);
		src_gap_pct = src_pct;
		snk_stall_pct = snk_pct;
	endtask

	task automatic send_sample(input logic [phd_pkg::LEVEL_W-1:0] s,
		input logic [phd_pkg::TIME_W-1:0] now);
		hit_result_t want;
		while (int'($urandom_range(99)) < src_gap_pct) begin
			in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.sample <= s;
		in_bus.now_ms <= now;
		do @(posedge clk); while (in_bus.ready !== 1'b1);
		predict_hit(s, now, want);
		hit_q.push_back(want);
		beats_sent++;
	endtask

	// called in the step of the last accepted beat, so valid gets one assignment
	task automatic drain_results();
		in_bus.valid <= 1'b0;
		while (hit_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(input logic [phd_pkg::LEVEL_W-1:0] sens,
		input logic [phd_pkg::LEVEL_W-1:0] thr, input logic [phd_pkg::LEVEL_W-1:0] deb);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= phd_pkg::CFG_SENSITIVITY;
		cfg_data <= sens;
		@(posedge clk);
		cfg_index <= phd_pkg::CFG_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		cfg_index <= phd_pkg::CFG_DEBOUNCE;
		cfg_data <= deb;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_sens = sens;
		cfg_thr = thr;
		cfg_debounce = deb;
		settings_loaded++;
	endtask

	// arm, latch start times across the 32-bit wrap, first peak, window at its edge
	task automatic test_arm_and_window();
		send_sample(10'd0, 32'h0000_0000);
		send_sample(10'd0, 32'hFFFF_FFFF);
		send_sample(10'd1, 32'h0000_0000);
		send_sample(10'd0, $urandom);
		send_sample(10'd0, 32'hAAAA_AAAA);
		send_sample(10'd0, 32'h5555_5555);
		send_sample(10'd0, 32'hFFFF_FFFC);
		send_sample(10'd2, 32'hFFFF_FFFD);
		send_sample(10'd5, 32'hFFFF_FFFE);
		send_sample(10'd1023, 32'hFFFF_FFFF);
		send_sample(10'd3, 32'h0000_0000);
		send_sample(10'd0, 32'h0000_0001);
		send_sample(10'd4, 32'h0000_0003);
	endtask

	// stays in the window: time never leaves the 7 ms span, the peak creeps up
	task automatic test_peak_velocity_sweep();
		int p;
		int roll;
		int x;
		logic [phd_pkg::LEVEL_W-1:0] sens;
		logic [phd_pkg::LEVEL_W-1:0] thr;
		logic [phd_pkg::LEVEL_W-1:0] deb;
		for (int seg = 0; seg < SWEEP_SEGMENTS; seg++) begin
			p = int'(peak_lvl);
			case (seg)
				0: begin
					sens = 10'd1023;
					thr = 10'd0;
				end
				1: begin
					sens = phd_pkg::LEVEL_W'($urandom_range(0, 1023));
					thr = sens;
				end
				2: begin
					sens = phd_pkg::LEVEL_W'($urandom_range(0, 511));
					thr = phd_pkg::LEVEL_W'($urandom_range(int'(sens) + 1, 1023));
				end
				3: begin
					thr = phd_pkg::LEVEL_W'($urandom_range(0, p));
					x = p + int'($urandom_range(1, 300));
					sens = (x > 1023) ? 10'd1023 : phd_pkg::LEVEL_W'(x);
				end
				4: begin
					sens = 10'd0;
					thr = 10'd1023;
				end
				default: begin
					sens = phd_pkg::LEVEL_W'($urandom_range(0, 1023));
					thr = phd_pkg::LEVEL_W'($urandom_range(0, 1023));
				end
			endcase
			case ($urandom_range(2))
				0: deb = 10'd0;
				1: deb = 10'd1023;
				default: deb = phd_pkg::LEVEL_W'($urandom_range(0, 1023));
			endcase
			load_settings(sens, thr, deb);
			for (int i = 0; i < SEGMENT_BEATS; i++) begin
				p = int'(peak_lvl);
				roll = int'($urandom_range(99));
				if (roll < 40)
					x = p + int'($urandom_range(1, 2));
				else if (roll < 85)
					x = int'($urandom_range(0, p));
				else
					x = p;
				if (x > 1023)
					x = 1023;
				send_sample(phd_pkg::LEVEL_W'(x),
					onset_ms + phd_pkg::TIME_W'($urandom_range(0, phd_pkg::PEAK_WINDOW_MS)));
			end
		end
	endtask

	// top peak, window expiry, note, then the falling phase with random beats
	task automatic test_note_and_fall();
		send_sample(10'd1023,
			onset_ms + phd_pkg::TIME_W'($urandom_range(0, phd_pkg::PEAK_WINDOW_MS)));
		send_sample(phd_pkg::LEVEL_W'($urandom_range(0, 1023)),
			onset_ms + phd_pkg::TIME_W'(phd_pkg::PEAK_WINDOW_MS + 1));
		for (int i = 0; i < FALL_BEATS; i++) begin
			if (i == FALL_BEATS / 2)
				load_settings(phd_pkg::LEVEL_W'($urandom_range(0, 1023)), 10'd1023, 10'd0);
			send_sample(phd_pkg::LEVEL_W'($urandom_range(0, 1023)), $urandom);
		end
	endtask

	always @(posedge clk)
		out_bus.ready <= (int'($urandom_range(99)) >= snk_stall_pct);

	always @(posedge clk) begin
		hit_result_t want;
		if (arst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
			if (hit_q.size() == 0) begin
				flag_mismatch("result beat with nothing pending");
			end else begin
				want = hit_q.pop_front();
				results_seen++;
				if (out_bus.hit_phase !== want.hit_phase)
					flag_mismatch($sformatf("beat %0d hit_phase %0d, predicted %0d",
						results_seen, out_bus.hit_phase, want.hit_phase));
				if (out_bus.note_on !== want.note_on)
					flag_mismatch($sformatf("beat %0d note_on %0b, predicted %0b",
						results_seen, out_bus.note_on, want.note_on));
				if (out_bus.velocity !== want.velocity)
					flag_mismatch($sformatf("beat %0d velocity %0d, predicted %0d",
						results_seen, out_bus.velocity, want.velocity));
				if (out_bus.peak_level !== want.peak_level)
					flag_mismatch($sformatf("beat %0d peak_level %0d, predicted %0d",
						results_seen, out_bus.peak_level, want.peak_level));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
			(out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_top: no beat moved for %0d cycles", STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		beats_sent = 0;
		results_seen = 0;
		settings_loaded = 0;
		vel_updates = 0;
		notes_due = 0;
		set_flow(0, 100);
		clear_hit_state();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= phd_pkg::CFG_SENSITIVITY;
		cfg_data <= '0;
		in_bus.valid <= 1'b0;
		in_bus.sample <= '0;
		in_bus.now_ms <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_flow(8, 64);
		test_arm_and_window();
		test_peak_velocity_sweep();
		set_flow(64, 8);
		test_peak_velocity_sweep();
		set_flow(0, 0);
		test_peak_velocity_sweep();
		test_note_and_fall();

		drain_results();
		repeat (30) @(posedge clk);
		if (hit_q.size() != 0)
			flag_mismatch($sformatf("%0d predicted results never arrived", hit_q.size()));

		$display("tb_top: %0d samples checked under %0d register settings, %0d velocity updates",
			beats_sent, settings_loaded, vel_updates);
		$display("tb_top: %0d notes, idle mixes 8/64, 64/8 and none, %0d mismatches",
			notes_due, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
